// ----- rtl/qfds_pkg.sv -----
`timescale 1ns / 1ps

package qfds_pkg;

  // Table size and derived widths
  localparam int unsigned MaxItems = 1024;
  localparam int unsigned IdxW     = $clog2(MaxItems);
  localparam int unsigned LinkW    = IdxW + 1;
  localparam int unsigned CntW     = IdxW;
  localparam int unsigned RangeW   = IdxW + 1;
  localparam int unsigned ModeW    = 2;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned InTdataW  = ((ModeW + 2 * IdxW + 7) / 8) * 8;
  localparam int unsigned OutTdataW = ((IdxW + 7) / 8) * 8;

  // Register port
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam logic        RegRangeSel = 1'b0;

  // Link value that ends a member chain
  localparam logic [LinkW-1:0] NoItem = LinkW'(MaxItems);

  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [LinkW-1:0]  link_t;
  typedef logic [CntW-1:0]   cnt_t;
  typedef logic [RangeW-1:0] range_t;

  typedef enum logic [ModeW-1:0] {
    ModeMake  = 2'd0,
    ModeFind  = 2'd1,
    ModeUnion = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StGotA,
    StGotB,
    StGotR1,
    StGotR2,
    StLose,
    StWalk,
    StOut
  } state_e;

  // One table entry per item
  typedef struct packed {
    logic  present;
    idx_t  root;
    link_t first;
    link_t next;
    cnt_t  count;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // Memory request from the sequencer
  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    idx_t   raddr;
  } mem_req_t;

endpackage

// ----- rtl/qfds_ram.sv -----
`timescale 1ns / 1ps

module qfds_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/qfds_cfg.sv -----
`timescale 1ns / 1ps

module qfds_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qfds_pkg::ApbAddrW-1:0]  paddr,
  input  logic [qfds_pkg::ApbDataW-1:0]  pwdata,
  output logic [qfds_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready,
  output qfds_pkg::range_t               range_o
);

  import qfds_pkg::*;

  range_t range_q, range_d;
  logic   wr_en;

  // Word select is bit 2; byte offset bits are ignored
  assign wr_en = psel && penable && pwrite && (paddr[2] == RegRangeSel);

  always_comb begin
    range_d = range_q;
    if (wr_en) begin
      range_d = pwdata[RangeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= range_t'(MaxItems);
    end else begin
      range_q <= range_d;
    end
  end

  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == RegRangeSel) ? ApbDataW'(range_q) : '0;
  assign range_o = range_q;

endmodule

// ----- rtl/qfds_ctrl.sv -----
`timescale 1ns / 1ps

module qfds_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  qfds_pkg::range_t                range_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [qfds_pkg::InTdataW-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [qfds_pkg::OutTdataW-1:0]  m_axis_tdata,
  output logic                            m_axis_tuser,
  output qfds_pkg::mem_req_t              mem_req_o,
  input  qfds_pkg::entry_t                mem_rdata_i
);

  import qfds_pkg::*;

  state_e state_q, state_d;
  idx_t   clr_q, clr_d;
  logic   m_valid_q, m_valid_d;

  mode_e  mode_q, mode_d;
  idx_t   a_q, a_d;
  idx_t   b_q, b_d;
  idx_t   r1_q, r1_d;
  idx_t   r2_q, r2_d;
  entry_t e1_q, e1_d;
  entry_t lose_q, lose_d;
  idx_t   lose_idx_q, lose_idx_d;
  idx_t   win_q, win_d;
  link_t  old_head_q, old_head_d;
  idx_t   cur_q, cur_d;
  idx_t   res_rep_q, res_rep_d;
  logic   res_stat_q, res_stat_d;
  idx_t   m_rep_q, m_rep_d;
  logic   m_stat_q, m_stat_d;

  mem_req_t req;
  entry_t   rd;
  entry_t   win_e;
  entry_t   lose_e;
  logic     r1_wins;
  logic     a_inr;
  logic     b_inr;
  idx_t     in_a;
  idx_t     in_b;
  mode_e    in_mode;

  assign rd      = mem_rdata_i;
  assign in_mode = mode_e'(s_axis_tdata[ModeW-1:0]);
  assign in_a    = s_axis_tdata[ModeW +: IdxW];
  assign in_b    = s_axis_tdata[ModeW + IdxW +: IdxW];

  // Range above the table size covers every item
  assign a_inr = range_t'(a_q) < range_i;
  assign b_inr = range_t'(b_q) < range_i;

  assign r1_wins = e1_q.count >= rd.count;
  assign win_e   = r1_wins ? e1_q : rd;
  assign lose_e  = r1_wins ? rd : e1_q;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    mode_d     = mode_q;
    a_d        = a_q;
    b_d        = b_q;
    r1_d       = r1_q;
    r2_d       = r2_q;
    e1_d       = e1_q;
    lose_d     = lose_q;
    lose_idx_d = lose_idx_q;
    win_d      = win_q;
    old_head_d = old_head_q;
    cur_d      = cur_q;
    res_rep_d  = res_rep_q;
    res_stat_d = res_stat_q;
    m_rep_d    = m_rep_q;
    m_stat_d   = m_stat_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    s_axis_tready = 1'b0;

    req       = '0;
    req.raddr = a_q;
    req.waddr = cur_q;
    req.wdata = rd;

    case (state_q)
      StClear: begin
        req.we    = 1'b1;
        req.waddr = clr_q;
        req.wdata = '0;
        clr_d     = clr_q + idx_t'(1);
        if (clr_q == idx_t'(MaxItems - 1)) begin
          state_d = StIdle;
        end
      end

      StIdle: begin
        s_axis_tready = 1'b1;
        req.raddr     = in_a;
        if (s_axis_tvalid) begin
          mode_d  = in_mode;
          a_d     = in_a;
          b_d     = in_b;
          state_d = StGotA;
        end
      end

      StGotA: begin
        res_rep_d  = '0;
        res_stat_d = 1'b1;
        state_d    = StOut;
        case (mode_q)
          ModeMake: begin
            if (a_inr) begin
              res_stat_d = 1'b0;
              if (rd.present) begin
                res_rep_d = rd.root;
              end else begin
                req.we            = 1'b1;
                req.waddr         = a_q;
                req.wdata.present = 1'b1;
                req.wdata.root    = a_q;
                req.wdata.first   = NoItem;
                req.wdata.count   = '0;
                res_rep_d         = a_q;
              end
            end
          end
          ModeFind: begin
            if (a_inr && rd.present) begin
              res_stat_d = 1'b0;
              res_rep_d  = rd.root;
            end
          end
          ModeUnion: begin
            if (a_inr && rd.present) begin
              r1_d      = rd.root;
              req.raddr = b_q;
              state_d   = StGotB;
            end
          end
          default: ;
        endcase
      end

      StGotB: begin
        state_d    = StOut;
        res_rep_d  = '0;
        res_stat_d = 1'b1;
        if (b_inr && rd.present) begin
          if (rd.root == r1_q) begin
            res_rep_d  = r1_q;
            res_stat_d = 1'b0;
          end else begin
            r2_d      = rd.root;
            req.raddr = r1_q;
            state_d   = StGotR1;
          end
        end
      end

      StGotR1: begin
        e1_d      = rd;
        req.raddr = r2_q;
        state_d   = StGotR2;
      end

      StGotR2: begin
        // Winner takes the loser as head of its chain
        win_d         = r1_wins ? r1_q : r2_q;
        lose_idx_d    = r1_wins ? r2_q : r1_q;
        lose_d        = lose_e;
        old_head_d    = win_e.first;
        req.we        = 1'b1;
        req.waddr     = r1_wins ? r1_q : r2_q;
        req.wdata       = win_e;
        req.wdata.count = win_e.count + lose_e.count + cnt_t'(1);
        req.wdata.first = link_t'(r1_wins ? r2_q : r1_q);
        state_d       = StLose;
      end

      StLose: begin
        req.we          = 1'b1;
        req.waddr       = lose_idx_q;
        req.wdata       = lose_q;
        req.wdata.root  = win_q;
        req.wdata.first = NoItem;
        req.wdata.next  = lose_q.first[IdxW] ? old_head_q : lose_q.first;
        req.raddr       = lose_q.first[IdxW-1:0];
        res_rep_d       = win_q;
        res_stat_d      = 1'b0;
        if (lose_q.first[IdxW]) begin
          state_d = StOut;
        end else begin
          cur_d   = lose_q.first[IdxW-1:0];
          state_d = StWalk;
        end
      end

      StWalk: begin
        // Re-point one member per cycle; the last one links to the old chain
        req.we         = 1'b1;
        req.waddr      = cur_q;
        req.wdata      = rd;
        req.wdata.root = win_q;
        req.wdata.next = rd.next[IdxW] ? old_head_q : rd.next;
        req.raddr      = rd.next[IdxW-1:0];
        if (rd.next[IdxW]) begin
          state_d = StOut;
        end else begin
          cur_d = rd.next[IdxW-1:0];
        end
      end

      StOut: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_rep_d   = res_rep_q;
          m_stat_d  = res_stat_q;
          state_d   = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    a_q        <= a_d;
    b_q        <= b_d;
    r1_q       <= r1_d;
    r2_q       <= r2_d;
    e1_q       <= e1_d;
    lose_q     <= lose_d;
    lose_idx_q <= lose_idx_d;
    win_q      <= win_d;
    old_head_q <= old_head_d;
    cur_q      <= cur_d;
    res_rep_q  <= res_rep_d;
    res_stat_q <= res_stat_d;
    m_rep_q    <= m_rep_d;
    m_stat_q   <= m_stat_d;
  end

  assign mem_req_o     = req;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OutTdataW'(m_rep_q);
  assign m_axis_tuser  = m_stat_q;

  // During the chain walk, a write back must never hit the entry being read in the same cycle
  a_no_rw_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.we && (state_q == StLose || state_q == StWalk) && state_d == StWalk)
      |-> (req.waddr != req.raddr))
    else $error("read and write to the same entry during chain walk");

  // A failed operation reports representative zero
  a_fail_rep_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_stat_q) |-> (m_rep_q == '0))
    else $error("nonzero representative with error status");

  // The clearing pass runs once after reset only
  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StClear) |=> (state_q != StClear))
    else $error("clearing pass re-entered");

  // Union winner and loser are distinct entries
  a_union_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLose) |-> (win_q != lose_idx_q))
    else $error("union merges a root into itself");

endmodule

// ----- rtl/quick_find_disjoint_sets_unit.sv -----
`timescale 1ns / 1ps

// Quick-find disjoint-set table with union by size, items 0 to range_in_use-1.
// Input stream (s_axis): one operation per transfer: make set, find or union.
// Output stream (m_axis): exactly one result per operation, in order: the
// representative in tdata and the error status in tuser.
// Register port: range_in_use at byte address 0, 11 bits, reset value 1024.
// Steps: make set and find read item a's entry, then load the result into the
// output register; a union also reads item b's entry and, if the roots
// differ, both root entries, then rewrites the winner and the loser and walks
// the absorbed set's chain, one non-root member per cycle, as the entry memory
// takes one read and one write per cycle: each member is one read-modify-write.
// One operation is in flight at a time; the next transfer is taken as soon as
// the result sits in the output register, even while the receiver stalls.
// If the receiver still holds the previous result, a finished operation waits
// until that one is taken.
// Reset: all 1024 entries of the entry memory are cleared in turn; s_axis_tready
// stays low during that pass, while register writes are taken as usual.
module quick_find_disjoint_sets_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // APB register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [qfds_pkg::ApbAddrW-1:0]   paddr,
  input  logic [qfds_pkg::ApbDataW-1:0]   pwdata,
  output logic [qfds_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready,
  // Operation stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [qfds_pkg::InTdataW-1:0]   s_axis_tdata,   // mode[1:0], item_a[11:2], item_b[21:12]
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [qfds_pkg::OutTdataW-1:0]  m_axis_tdata,   // representative[9:0]
  output logic                            m_axis_tuser    // status[0]
);

  import qfds_pkg::*;

  range_t   range_in_use;
  mem_req_t mem_req;
  entry_t   mem_rdata;

  // Register block: holds range_in_use
  qfds_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .range_o (range_in_use)
  );

  // Sequencer: clear pass, lookups, merge and chain walk, output register
  qfds_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .range_i       (range_in_use),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata)
  );

  // Entry memory: presence, root, chain head, chain link and member count
  qfds_ram #(
    .Width (EntryW),
    .Depth (MaxItems)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule
